// ----- src/squeeze_inverse_line_core_macros.svh -----
// Assertion macros shared by the inverse squeeze line modules.
// Each macro expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef SQUEEZE_INVERSE_LINE_CORE_MACROS_SVH
`define SQUEEZE_INVERSE_LINE_CORE_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define SIL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define SIL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sil_pkg.sv -----
// Shared types and constants for the inverse squeeze line core.
// No dependencies; used by sil_front, sil_queue, sil_back and the top level.
package sil_pkg;

    // Width of a sample as carried on the ports and in queued operations.
    localparam int DATA_BITS = 32;

    // Operation queue between the front and the back part.
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Rounding bias of the tendency numerator.
    localparam int TEND_BIAS = 6;

    // Division by three in two halves: the quotient magnitude is split at bit 16.
    localparam int DIV_SPLIT_BITS = 16;
    localparam int DIV_HI_BITS    = 17;
    localparam int DIV_HI_SHIFT   = 18;
    localparam int DIV_LO_SHIFT   = 19;
    localparam logic [16:0] DIV3_RECIP_HI = 17'd87382;
    localparam logic [17:0] DIV3_RECIP_LO = 18'd174763;

    // Kind of work handed from the front to the back.
    typedef enum logic {
        OP_REBUILD,
        OP_LONE
    } op_kind_t;

    // One queued operation. Samples are held sign-extended to DATA_BITS.
    typedef struct packed {
        op_kind_t                     kind;
        logic signed [DATA_BITS-1:0]  avg;
        logic signed [DATA_BITS-1:0]  res;
        logic signed [DATA_BITS-1:0]  next;
        logic                         set_left;
        logic                         eol;
        logic                         eor;
    } op_t;

    // Sequencer states of the back part.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIVH,
        ST_DIVL,
        ST_CLAMP,
        ST_DIFF,
        ST_EMIT1,
        ST_EMIT2,
        ST_LONE
    } back_state_t;

endpackage

// ----- src/sil_front.sv -----
// Front part: accepts input requests, keeps the held pair and turns each request
// into zero, one or two queued operations. Depends on sil_pkg.
`include "squeeze_inverse_line_core_macros.svh"

module sil_front #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sil_pkg::DATA_BITS-1:0]     in_avg,
    input  logic [sil_pkg::DATA_BITS-1:0]     in_res,
    input  logic                              in_has_res,
    input  logic                              in_last,
    output logic                              push_valid,
    output sil_pkg::op_t                      push_op,
    input  logic                              push_ready
);

    localparam int W  = SAMPLE_BITS;
    localparam int DB = sil_pkg::DATA_BITS;

    logic signed [W-1:0] avg_w;
    logic signed [W-1:0] res_w;
    logic                lone;
    logic                last;
    logic                accept;
    sil_pkg::op_t        op_held;
    sil_pkg::op_t        op_end;

    logic signed [W-1:0] held_avg_reg, held_avg_next;
    logic signed [W-1:0] held_res_reg, held_res_next;
    logic                held_valid_reg, held_valid_next;
    logic                held_first_reg, held_first_next;
    logic                pend_valid_reg, pend_valid_next;
    sil_pkg::op_t        pend_reg, pend_next;

    // Samples are taken in their low SAMPLE_BITS bits.
    assign avg_w  = in_avg[W-1:0];
    assign res_w  = in_res[W-1:0];
    assign lone   = !in_has_res;
    assign last   = in_last || lone;
    assign accept = in_valid && in_ready;

    // A request that needs two operations parks its second one, so no new request meanwhile.
    assign in_ready = !pend_valid_reg && push_ready;

    // Operations that a request may cause.
    always_comb begin
        op_held.kind     = sil_pkg::OP_REBUILD;
        op_held.avg      = DB'(held_avg_reg);
        op_held.res      = DB'(held_res_reg);
        op_held.next     = DB'(avg_w);
        op_held.set_left = held_first_reg;
        op_held.eol      = 1'b0;
        op_held.eor      = !last;

        op_end.avg       = DB'(avg_w);
        op_end.eol       = 1'b1;
        op_end.eor       = 1'b1;
        if (lone) begin
            op_end.kind     = sil_pkg::OP_LONE;
            op_end.res      = '0;
            op_end.next     = '0;
            op_end.set_left = 1'b0;
        end else begin
            op_end.kind     = sil_pkg::OP_REBUILD;
            op_end.res      = DB'(res_w);
            op_end.next     = DB'(avg_w);
            op_end.set_left = !held_valid_reg;
        end
    end

    // Queue push: a parked operation goes first.
    always_comb begin
        push_valid = pend_valid_reg || (accept && (held_valid_reg || last));
        if (pend_valid_reg) begin
            push_op = pend_reg;
        end else if (held_valid_reg) begin
            push_op = op_held;
        end else begin
            push_op = op_end;
        end
    end

    // Held pair and parked operation.
    always_comb begin
        held_avg_next   = held_avg_reg;
        held_res_next   = held_res_reg;
        held_valid_next = held_valid_reg;
        held_first_next = held_first_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;

        if (pend_valid_reg && push_ready) begin
            pend_valid_next = 1'b0;
        end

        if (accept) begin
            if (held_valid_reg && last) begin
                pend_valid_next = 1'b1;
                pend_next       = op_end;
            end
            if (last) begin
                held_valid_next = 1'b0;
            end else begin
                held_valid_next = 1'b1;
                held_first_next = !held_valid_reg;
                held_avg_next   = avg_w;
                held_res_next   = res_w;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_first_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            held_valid_reg <= held_valid_next;
            held_first_reg <= held_first_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        held_avg_reg <= held_avg_next;
        held_res_reg <= held_res_next;
        pend_reg     <= pend_next;
    end

    `SIL_ASSERT_NEXT(a_lone_ends_line, accept && lone, !held_valid_reg, "lone average left a pair held")
    `SIL_ASSERT_NOW(a_parked_ends_run, pend_valid_reg, pend_reg.eor && pend_reg.eol, "parked operation does not close the line")

endmodule

// ----- src/sil_queue.sv -----
// Short operation queue between the front and the back part.
// Depends on sil_pkg for the operation type and the depth.
`include "squeeze_inverse_line_core_macros.svh"

module sil_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    input  sil_pkg::op_t  push_op,
    output logic          push_ready,
    output logic          pop_valid,
    output sil_pkg::op_t  pop_op,
    input  logic          pop_ready
);

    localparam int PB = sil_pkg::QUEUE_PTR_BITS;
    localparam int CB = sil_pkg::QUEUE_CNT_BITS;

    sil_pkg::op_t    mem_reg [sil_pkg::QUEUE_DEPTH];
    logic [PB-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PB-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CB-1:0]   count_reg, count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != CB'(sil_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill level update; the depth is a power of two, so pointers wrap.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    `SIL_ASSERT_NOW(a_fill_bound, 1'b1, count_reg <= CB'(sil_pkg::QUEUE_DEPTH), "queue overfilled")
    `SIL_ASSERT_NEXT(a_fill_grows, push && !pop, count_reg == $past(count_reg) + 1'b1, "fill level lost a push")

endmodule

// ----- src/sil_back.sv -----
// Back part: sequencer that rebuilds one pair at a time (tendency, divide by twelve,
// clamping, residual) and drives the registered result channel. Depends on sil_pkg.
`include "squeeze_inverse_line_core_macros.svh"

module sil_back #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           pop_valid,
    input  sil_pkg::op_t                   pop_op,
    output logic                           pop_ready,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sil_pkg::DATA_BITS-1:0]  out_sample,
    output logic                           out_eor,
    output logic                           out_eol
);

    localparam int W  = SAMPLE_BITS;
    localparam int NW = SAMPLE_BITS + 4;
    localparam int MW = SAMPLE_BITS + 1;
    localparam int DB = sil_pkg::DATA_BITS;

    sil_pkg::back_state_t state_reg, state_next;
    sil_pkg::op_t         op_reg, op_next;

    logic signed [W-1:0]  left_reg, left_next;
    logic                 dec_reg, dec_next;
    logic                 inc_reg, inc_next;
    logic                 neg_reg, neg_next;
    logic [MW-1:0]        m_reg, m_next;
    logic signed [NW-1:0] da_reg, da_next;
    logic signed [NW-1:0] db_reg, db_next;
    logic [sil_pkg::DIV_HI_BITS-1:0] qh_reg, qh_next;
    logic signed [NW-1:0] x_reg, x_next;
    logic signed [W-1:0]  t_reg, t_next;
    logic signed [W-1:0]  diff_reg, diff_next;
    logic signed [W-1:0]  first_reg, first_next;

    logic                 o_valid_reg, o_valid_next;
    logic [DB-1:0]        o_sample_reg, o_sample_next;
    logic                 o_eor_reg, o_eor_next;
    logic                 o_eol_reg, o_eol_next;

    logic signed [W-1:0]  a;
    logic signed [W-1:0]  b;
    logic signed [W-1:0]  c;
    logic signed [W-1:0]  res;
    logic signed [NW-1:0] ae;
    logic signed [NW-1:0] be;
    logic signed [NW-1:0] ce;
    logic signed [NW-1:0] base;
    logic signed [NW-1:0] num;
    logic [NW-1:0]        mag;
    logic [sil_pkg::DIV_HI_BITS-1:0] mh;
    logic [34:0]          prod_h;
    logic [1:0]           rh;
    logic [17:0]          x_lo;
    logic [35:0]          prod_l;
    logic [15:0]          ql;
    logic signed [NW-1:0] q_ext;
    logic signed [NW-1:0] x1;
    logic signed [NW-1:0] x2;
    logic signed [NW-1:0] par1;
    logic signed [NW-1:0] par2;
    logic [W:0]           d_wide;
    logic signed [W-1:0]  half;
    logic signed [W-1:0]  first;
    logic signed [W-1:0]  second;
    logic                 out_free;
    logic                 finish;
    logic                 take;

    // Operands of the current operation, wrapped to the sample width.
    assign a   = left_reg;
    assign b   = op_reg.avg[W-1:0];
    assign c   = op_reg.next[W-1:0];
    assign res = op_reg.res[W-1:0];
    assign ae  = NW'(a);
    assign be  = NW'(b);
    assign ce  = NW'(c);

    // Tendency numerator and its magnitude over four.
    always_comb begin
        base = (ae <<< 2) - (ce + (ce <<< 1)) - be;
        num  = (a >= b && b >= c) ? base + NW'(sil_pkg::TEND_BIAS)
                                  : base - NW'(sil_pkg::TEND_BIAS);
        mag  = num[NW-1] ? -num : num;
    end

    // Divide the magnitude by three: upper half first, then remainder with lower half.
    always_comb begin
        mh     = sil_pkg::DIV_HI_BITS'(m_reg >> sil_pkg::DIV_SPLIT_BITS);
        prod_h = 35'(mh) * 35'(sil_pkg::DIV3_RECIP_HI);
        rh     = mh[1:0] - (qh_reg[1:0] + {qh_reg[0], 1'b0});
        x_lo   = {rh, m_reg[sil_pkg::DIV_SPLIT_BITS-1:0]};
        prod_l = 36'(x_lo) * 36'(sil_pkg::DIV3_RECIP_LO);
        ql     = prod_l[sil_pkg::DIV_LO_SHIFT+15:sil_pkg::DIV_LO_SHIFT];
        q_ext  = NW'({qh_reg, ql});
    end

    // Clamp the tendency against both slopes.
    always_comb begin
        par1 = {{(NW-1){1'b0}}, x_reg[0]};
        x1   = x_reg;
        x2   = '0;
        par2 = '0;
        if (dec_reg) begin
            if (x_reg - par1 > da_reg) begin
                x1 = da_reg + NW'(1);
            end
            par2 = {{(NW-1){1'b0}}, x1[0]};
            x2   = (x1 + par2 > db_reg) ? db_reg : x1;
        end else if (inc_reg) begin
            if (x_reg + par1 < da_reg) begin
                x1 = da_reg - NW'(1);
            end
            par2 = {{(NW-1){1'b0}}, x1[0]};
            x2   = (x1 - par2 < db_reg) ? db_reg : x1;
        end
    end

    // Samples of the pair: half the difference rounds toward zero.
    always_comb begin
        d_wide = (W+1)'(diff_reg) + {{W{1'b0}}, diff_reg[W-1]};
        half   = d_wide[W:1];
        first  = b + half;
        second = first_reg - diff_reg;
    end

    // Handshake between the sequencer, the queue and the output register.
    assign out_free  = !o_valid_reg || out_ready;
    assign finish    = (state_reg == sil_pkg::ST_EMIT2 || state_reg == sil_pkg::ST_LONE)
                       && out_free;
    assign pop_ready = (state_reg == sil_pkg::ST_IDLE) || finish;
    assign take      = pop_ready && pop_valid;

    // Sequencer: next state, datapath loads and output register.
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        left_next     = left_reg;
        dec_next      = dec_reg;
        inc_next      = inc_reg;
        neg_next      = neg_reg;
        m_next        = m_reg;
        da_next       = da_reg;
        db_next       = db_reg;
        qh_next       = qh_reg;
        x_next        = x_reg;
        t_next        = t_reg;
        diff_next     = diff_reg;
        first_next    = first_reg;
        o_valid_next  = out_ready ? 1'b0 : o_valid_reg;
        o_sample_next = o_sample_reg;
        o_eor_next    = o_eor_reg;
        o_eol_next    = o_eol_reg;

        unique case (state_reg)
            sil_pkg::ST_IDLE: begin
            end
            sil_pkg::ST_SUM: begin
                dec_next   = (a >= b) && (b >= c);
                inc_next   = (a <= b) && (b <= c);
                neg_next   = num[NW-1];
                m_next     = mag[MW+1:2];
                da_next    = (ae - be) <<< 1;
                db_next    = (be - ce) <<< 1;
                state_next = sil_pkg::ST_DIVH;
            end
            sil_pkg::ST_DIVH: begin
                qh_next    = prod_h[sil_pkg::DIV_HI_SHIFT+sil_pkg::DIV_HI_BITS-1:
                                    sil_pkg::DIV_HI_SHIFT];
                state_next = sil_pkg::ST_DIVL;
            end
            sil_pkg::ST_DIVL: begin
                x_next     = neg_reg ? -q_ext : q_ext;
                state_next = sil_pkg::ST_CLAMP;
            end
            sil_pkg::ST_CLAMP: begin
                t_next     = x2[W-1:0];
                state_next = sil_pkg::ST_DIFF;
            end
            sil_pkg::ST_DIFF: begin
                diff_next  = res + t_reg;
                state_next = sil_pkg::ST_EMIT1;
            end
            sil_pkg::ST_EMIT1: begin
                if (out_free) begin
                    o_valid_next  = 1'b1;
                    o_sample_next = DB'(first);
                    o_eor_next    = 1'b0;
                    o_eol_next    = 1'b0;
                    first_next    = first;
                    state_next    = sil_pkg::ST_EMIT2;
                end
            end
            sil_pkg::ST_EMIT2: begin
                if (out_free) begin
                    o_valid_next  = 1'b1;
                    o_sample_next = DB'(second);
                    o_eor_next    = op_reg.eor;
                    o_eol_next    = op_reg.eol;
                    left_next     = second;
                    state_next    = sil_pkg::ST_IDLE;
                end
            end
            sil_pkg::ST_LONE: begin
                if (out_free) begin
                    o_valid_next  = 1'b1;
                    o_sample_next = DB'(b);
                    o_eor_next    = op_reg.eor;
                    o_eol_next    = op_reg.eol;
                    state_next    = sil_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sil_pkg::ST_IDLE;
            end
        endcase

        // Start the next operation; a new line loads its own left sample.
        if (take) begin
            op_next = pop_op;
            if (pop_op.set_left) begin
                left_next = pop_op.avg[W-1:0];
            end
            state_next = (pop_op.kind == sil_pkg::OP_LONE) ? sil_pkg::ST_LONE
                                                           : sil_pkg::ST_SUM;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sil_pkg::ST_IDLE;
            o_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // Datapath and output payload.
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        left_reg     <= left_next;
        dec_reg      <= dec_next;
        inc_reg      <= inc_next;
        neg_reg      <= neg_next;
        m_reg        <= m_next;
        da_reg       <= da_next;
        db_reg       <= db_next;
        qh_reg       <= qh_next;
        x_reg        <= x_next;
        t_reg        <= t_next;
        diff_reg     <= diff_next;
        first_reg    <= first_next;
        o_sample_reg <= o_sample_next;
        o_eor_reg    <= o_eor_next;
        o_eol_reg    <= o_eol_next;
    end

    assign out_valid  = o_valid_reg;
    assign out_sample = o_sample_reg;
    assign out_eor    = o_eor_reg;
    assign out_eol    = o_eol_reg;

    `SIL_ASSERT_NEXT(a_sum_to_div, state_reg == sil_pkg::ST_SUM, state_reg == sil_pkg::ST_DIVH, "divide step skipped")
    `SIL_ASSERT_NOW(a_eol_ends_run, o_valid_reg && o_eol_reg, o_eor_reg, "line end without run end")

endmodule

// ----- src/squeeze_inverse_line_core.sv -----
// Inverse squeeze line core: top level joining front, operation queue and back.
// Depends on sil_pkg, sil_front, sil_queue and sil_back.
//
// Rebuilds a line of samples from averages and residuals. Each input request
// carries one average with its residual, or (has_residual low, on tuser) a lone
// final average; tlast marks the final average of a line. A pair is held until
// the next average arrives, then two samples leave one per cycle on the result
// channel while it is ready, with tuser marking the last result of a request
// and tlast the final sample of a line. Samples are processed in their low
// SAMPLE_BITS bits and come back sign-extended to 32 bits. The front accepts a
// request per cycle while the four-entry queue has room (a request that closes
// a held line parks its second operation and holds off the next request). The
// back rebuilds one pair at a time in the steps sum, two halves of the divide
// by twelve, clamp, residual, and one output step for each sample; the next
// pair depends on the last sample of this one. A lone average takes a single
// output step.
`include "squeeze_inverse_line_core_macros.svh"

module squeeze_inverse_line_core #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] avg_value, [63:32] residual_value
    input  logic        s_tuser,   // [0] has_residual
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sample_value
    output logic        m_tuser,   // [0] end_of_run
    output logic        m_tlast
);

    logic         push_valid;
    logic         push_ready;
    sil_pkg::op_t push_op;
    logic         pop_valid;
    logic         pop_ready;
    sil_pkg::op_t pop_op;

    // Request classification and held pair.
    sil_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_avg     (s_tdata[31:0]),
        .in_res     (s_tdata[63:32]),
        .in_has_res (s_tuser),
        .in_last    (s_tlast),
        .push_valid (push_valid),
        .push_op    (push_op),
        .push_ready (push_ready)
    );

    // Operation queue.
    sil_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_op    (push_op),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_op     (pop_op),
        .pop_ready  (pop_ready)
    );

    // Pair rebuild and result register.
    sil_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_op     (pop_op),
        .pop_ready  (pop_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (m_tdata),
        .out_eor    (m_tuser),
        .out_eol    (m_tlast)
    );

endmodule

// ----- dv/tb_squeeze_inverse_line_core.sv -----
// Self-checking testbench for squeeze_inverse_line_core on its stream ports.
// Needs only the RTL of the core; expected samples come from a predictor kept in this file.
module tb_squeeze_inverse_line_core;

    localparam int SAMPLE_BITS = 32;
    // Generous ceiling on the whole run, in time units (clock period is 4).
    localparam int RUN_LIMIT   = 2000000;
    // Cycles allowed for the core to settle after the last expected sample.
    localparam int SETTLE_CYCLES = 40;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;     // [31:0] avg_value, [63:32] residual_value
    logic        s_tuser  = 1'b0;   // [0] has_residual
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] sample_value
    logic        m_tuser;           // [0] end_of_run
    logic        m_tlast;

    // One expected sample on the result channel.
    typedef struct packed {
        logic [31:0] sample;
        logic        eor;
        logic        eol;
    } sample_rec_t;

    sample_rec_t sample_q[$];
    sample_rec_t batch[4];
    int          batch_n;

    // Predictor state: the pair waiting for its next average and the left sample.
    longint pend_avg;
    longint pend_res;
    bit     pend_vld;
    longint left_smp;

    int err_count  = 0;
    int sent_count = 0;
    int hold_left  = 0;
    bit steady     = 1'b0;

    squeeze_inverse_line_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Keep the low SAMPLE_BITS bits of a value and sign-extend them.
    function automatic longint wrap_smp(longint x);
        longint m;
        m = x & ((longint'(1) << SAMPLE_BITS) - 1);
        if (m[SAMPLE_BITS-1]) begin
            m = m - (longint'(1) << SAMPLE_BITS);
        end
        return m;
    endfunction

    // Tendency from the left sample, the current average and the next average.
    function automatic longint tendency_of(longint a, longint b, longint c);
        longint x;
        if (a >= b && b >= c) begin
            x = (4 * a - 3 * c - b + 6) / 12;
            if (x - longint'(x[0]) > 2 * (a - b)) begin
                x = 2 * (a - b) + 1;
            end
            if (x + longint'(x[0]) > 2 * (b - c)) begin
                x = 2 * (b - c);
            end
            return x;
        end
        if (a <= b && b <= c) begin
            x = (4 * a - 3 * c - b - 6) / 12;
            if (x + longint'(x[0]) < 2 * (a - b)) begin
                x = 2 * (a - b) - 1;
            end
            if (x - longint'(x[0]) < 2 * (b - c)) begin
                x = 2 * (b - c);
            end
            return x;
        end
        return 0;
    endfunction

    task automatic add_sample(longint v, bit eol);
        batch[batch_n].sample = 32'(v);
        batch[batch_n].eor    = 1'b0;
        batch[batch_n].eol    = eol;
        batch_n++;
    endtask

    // Rebuild two samples of a pair and move the left sample on.
    task automatic rebuild_pair(longint avg, longint res, longint next, bit eol);
        longint diff;
        longint first;
        longint second;
        diff   = wrap_smp(res + wrap_smp(tendency_of(left_smp, avg, next)));
        first  = wrap_smp(avg + diff / 2);
        second = wrap_smp(first - diff);
        add_sample(first, 1'b0);
        add_sample(second, eol);
        left_smp = second;
    endtask

    // Work out the samples that one accepted request releases.
    task automatic predict_request(logic [31:0] avg_in, logic [31:0] res_in,
                                   logic has_res, logic last_in);
        longint avg;
        longint res;
        bit     ends_line;
        avg       = wrap_smp(longint'(avg_in));
        res       = wrap_smp(longint'(res_in));
        ends_line = last_in || !has_res;
        batch_n   = 0;
        if (!pend_vld) begin
            left_smp = avg;
        end else begin
            rebuild_pair(pend_avg, pend_res, avg, 1'b0);
        end
        if (!has_res) begin
            add_sample(avg, 1'b1);
            pend_vld = 1'b0;
        end else if (ends_line) begin
            rebuild_pair(avg, res, avg, 1'b1);
            pend_vld = 1'b0;
        end else begin
            pend_avg = avg;
            pend_res = res;
            pend_vld = 1'b1;
        end
        if (batch_n > 0) begin
            batch[batch_n-1].eor = 1'b1;
        end
        for (int i = 0; i < batch_n; i++) begin
            sample_q.push_back(batch[i]);
        end
    endtask

    // Offer one request, at times after a random gap, and wait for its handshake.
    task automatic send_request(logic [31:0] avg, logic [31:0] res,
                                logic has_res, logic last_in);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 7) begin
            gap = $urandom_range(1, 6);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {res, avg};
        s_tuser  <= has_res;
        s_tlast  <= last_in;
        do @(posedge aclk); while (!s_tready);
        predict_request(avg, res, has_res, last_in);
        sent_count++;
    endtask

    // Stop offering and wait until every expected sample has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sample_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Average of the k-th position of a line in one of three value styles.
    function automatic logic [31:0] line_value(int style, int base, int step, int k);
        if (style == 0) begin
            return $urandom;
        end else if (style == 1) begin
            return base + k * step;
        end
        return base + int'($urandom_range(0, 200)) - 100;
    endfunction

    function automatic logic [31:0] residual_value(int style);
        if (style == 0 || $urandom_range(0, 9) == 0) begin
            return $urandom;
        end
        return int'($urandom_range(0, 40)) - 20;
    endfunction

    // One well-formed line: pairs, optionally closed by a lone average.
    task automatic send_line(int pairs, bit odd);
        int style;
        int base;
        int step;
        style = $urandom_range(0, 2);
        base  = int'($urandom_range(0, 4000)) - 2000;
        step  = int'($urandom_range(0, 600)) - 300;
        for (int k = 0; k < pairs; k++) begin
            send_request(line_value(style, base, step, k), residual_value(style), 1'b1,
                         (k == pairs - 1) && !odd);
        end
        if (odd) begin
            send_request(line_value(style, base, step, pairs), $urandom, 1'b0, 1'b1);
        end
    endtask

    // Mostly proper lines, with some requests whose flags are random.
    task automatic send_random_lines(int count);
        int target;
        int pairs;
        bit odd;
        target = sent_count + count;
        while (sent_count < target) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_request($urandom, $urandom, 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
                end
            end else begin
                pairs = $urandom_range(0, 8);
                odd   = (pairs == 0) ? 1'b1 : 1'($urandom_range(0, 1));
                send_line(pairs, odd);
            end
        end
    endtask

    // Field extremes, every line shape and the clamping and wrapping cases.
    task automatic test_directed();
        // A lone average makes a line of one sample, marked last or not.
        send_request(32'h7fffffff, 32'h12345678, 1'b0, 1'b1);
        send_request(32'h80000000, 32'hffffffff, 1'b0, 1'b0);
        // A pair that is last with nothing held makes a line of two.
        send_request(32'd100, -32'sd7, 1'b1, 1'b1);
        // A held pair closed by a lone average.
        send_request(32'd10, 32'd3, 1'b1, 1'b0);
        send_request(-32'sd5, 32'd99, 1'b0, 1'b1);
        // A held pair closed by a final pair: four samples from one request.
        send_request(32'd1000, 32'd1, 1'b1, 1'b0);
        send_request(32'd200, -32'sd3, 1'b1, 1'b1);
        // Falling and rising lines, so that the tendency is limited.
        send_request(32'd900, 32'd0, 1'b1, 1'b0);
        send_request(32'd600, 32'd0, 1'b1, 1'b0);
        send_request(32'd300, 32'd5, 1'b1, 1'b0);
        send_request(32'd0, -32'sd2, 1'b1, 1'b1);
        send_request(-32'sd900, 32'd0, 1'b1, 1'b0);
        send_request(-32'sd600, 32'd3, 1'b1, 1'b0);
        send_request(-32'sd300, 32'd0, 1'b1, 1'b0);
        send_request(32'd0, 32'd0, 1'b0, 1'b1);
        // Sums and differences that wrap at the sample width.
        send_request(32'h7fffffff, 32'h7fffffff, 1'b1, 1'b0);
        send_request(32'h80000000, 32'h80000000, 1'b1, 1'b0);
        send_request(32'h7fffffff, 32'h80000000, 1'b1, 1'b1);
        send_request(32'd0, 32'h7fffffff, 1'b1, 1'b0);
        send_request(32'd0, 32'h80000000, 1'b1, 1'b1);
        send_request(32'd0, 32'd0, 1'b1, 1'b1);
        wait_drained();
    endtask

    // The result side holds off while requests keep coming, so the core stalls.
    task automatic test_backpressure();
        hold_left = 300;
        repeat (4) send_line(4, 1'b0);
        wait_drained();
    endtask

    // Neither side idles for a stretch, so the core runs at full rate.
    task automatic test_steady_stream();
        steady = 1'b1;
        send_random_lines(50);
        steady = 1'b0;
    endtask

    // Result side: random stalls, the long hold-off, and the sample check.
    always @(posedge aclk) begin
        sample_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (sample_q.size() == 0) begin
                $display("%0t: unexpected sample %h (end_of_run %b, end_of_line %b)",
                         $time, m_tdata, m_tuser, m_tlast);
                err_count++;
            end else begin
                want = sample_q.pop_front();
                if (m_tdata !== want.sample) begin
                    $display("%0t: sample_value expected %h, got %h",
                             $time, want.sample, m_tdata);
                    err_count++;
                end
                if (m_tuser !== want.eor) begin
                    $display("%0t: end_of_run expected %b, got %b", $time, want.eor, m_tuser);
                    err_count++;
                end
                if (m_tlast !== want.eol) begin
                    $display("%0t: end_of_line expected %b, got %b", $time, want.eol, m_tlast);
                    err_count++;
                end
            end
        end
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left = hold_left - 1;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 7);
        end
    end

    // Main sequence of tests.
    initial begin
        pend_avg = 0;
        pend_res = 0;
        pend_vld = 1'b0;
        left_smp = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        send_random_lines(60);
        test_backpressure();
        test_steady_stream();
        send_random_lines(30);
        wait_drained();
        if (err_count == 0) begin
            $display("tb_squeeze_inverse_line_core OK");
        end else begin
            $display("tb_squeeze_inverse_line_core NOT OK");
        end
        $finish;
    end

    // Watchdog for a core that hangs.
    initial begin
        #(RUN_LIMIT);
        $display("%0t: timeout with %0d samples outstanding", $time, sample_q.size());
        $display("tb_squeeze_inverse_line_core NOT OK");
        $finish;
    end

endmodule
